FILE: hdl/wsts_pkg.sv
// Package: shared constants and types for the weighted server scheduler.
package wsts_pkg;
  localparam int MAX_SERVERS = 16;
  localparam int IDX_W = $clog2(MAX_SERVERS);
  localparam int CNT_W = $clog2(MAX_SERVERS + 1);
  localparam int TIME_W = 48;
  localparam int WEIGHT_W = 16;
  localparam int DUR_W = 16;
  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  localparam logic [1:0] FUNC_CLEAR = 2'd0;
  localparam logic [1:0] FUNC_LOAD = 2'd1;
  localparam logic [1:0] FUNC_TASK = 2'd2;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  typedef struct packed {
    logic clear;
    logic load;
    logic load_sel;
    logic release_en;
    logic assign_en;
    logic assign_sel;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] fin;
    logic [WEIGHT_W-1:0] weight;
  } cell_ctrl_t;

  typedef struct packed {
    logic valid;
    logic busy_found;
    logic idle_found;
    logic [TIME_W-1:0] earliest;
    logic [WEIGHT_W-1:0] best_weight;
    logic [IDX_W-1:0] best_idx;
  } scan_t;
endpackage

FILE: hdl/wsts_if.sv
// Interfaces: request and result channels.
interface wsts_req_if;
  logic valid;
  logic ready;
  logic [1:0] func;
  logic [15:0] server_weight;
  logic [15:0] task_duration;
  modport source(output valid, func, server_weight, task_duration, input ready);
  modport sink(input valid, func, server_weight, task_duration, output ready);
endinterface

interface wsts_res_if;
  logic valid;
  logic ready;
  logic [3:0] assigned_server;
  logic [47:0] start_time;
  logic no_server;
  modport source(output valid, assigned_server, start_time, no_server, input ready);
  modport sink(input valid, assigned_server, start_time, no_server, output ready);
endinterface

FILE: hdl/wsts_cell.sv
// Server cell: holds one server and folds its state into the scan chain.
module wsts_cell (
  input  logic clk,
  input  logic rst,
  input  logic [wsts_pkg::IDX_W-1:0] idx,
  input  wsts_pkg::cell_ctrl_t ctrl,
  input  wsts_pkg::scan_t scan_in,
  output wsts_pkg::scan_t scan_out
);
  import wsts_pkg::*;

  logic [WEIGHT_W-1:0] weight;
  logic [TIME_W-1:0] finish;
  logic loaded;
  logic busy;

  always_ff @(posedge clk) begin
    if (ctrl.load && ctrl.load_sel) begin
      weight <= ctrl.weight;
    end
    if (ctrl.assign_en && ctrl.assign_sel) begin
      finish <= ctrl.fin;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      loaded <= 1'b0;
      busy <= 1'b0;
    end else if (ctrl.load && ctrl.load_sel) begin
      loaded <= 1'b1;
      busy <= 1'b0;
    end else if (ctrl.assign_en && ctrl.assign_sel) begin
      busy <= 1'b1;
    end else if (ctrl.release_en && busy && finish <= ctrl.now) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    scan_out <= scan_in;
    if (scan_in.valid && loaded) begin
      if (busy) begin
        scan_out.busy_found <= 1'b1;
        if (!scan_in.busy_found || finish < scan_in.earliest) begin
          scan_out.earliest <= finish;
        end
      end else begin
        scan_out.idle_found <= 1'b1;
        if (!scan_in.idle_found || weight < scan_in.best_weight) begin
          scan_out.best_weight <= weight;
          scan_out.best_idx <= idx;
        end
      end
    end
  end
endmodule

FILE: hdl/weighted_server_task_scheduler_core.sv
// Top level: weighted server task scheduler with a chain of server cells.
// Clear and load requests are handled in the idle state; a task passes through
// a scan for the earliest finish, a release, a second scan for the lightest idle
// server and assignment, and only then is the next request taken. A task with no
// servers answers on the next cycle.
// A waiting result holds off requests; synchronous reset empties the schedule.
module weighted_server_task_scheduler_core (
  input logic clk,
  input logic rst,
  wsts_req_if.sink req,
  wsts_res_if.source res
);
  import wsts_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN1 = 5'b00010,
    S_REL = 5'b00100,
    S_SCAN2 = 5'b01000,
    S_ASSIGN = 5'b10000
  } state_t;

  state_t state;
  logic [CNT_W-1:0] server_count;
  logic [TIME_W-1:0] current_time;
  logic [TIME_W-1:0] task_counter;
  logic [TIME_W-1:0] arrival;
  logic [DUR_W-1:0] dur;
  logic [IDX_W:0] step;
  logic [TIME_W:0] fin_sum;
  logic res_pending;

  cell_ctrl_t ctrl;
  scan_t chain [MAX_SERVERS+1];
  scan_t scan_head;
  scan_t last;

  logic accept;
  logic res_set_empty;
  logic res_set_task;
  assign req.ready = (state == S_IDLE) && (!res.valid || res.ready || !res_pending);
  assign accept = req.valid && req.ready;
  assign last = chain[MAX_SERVERS];
  assign fin_sum = {1'b0, current_time} + {{(TIME_W+1-DUR_W){1'b0}}, dur};
  assign res_set_empty = accept && req.func == FUNC_TASK && server_count == '0;
  assign res_set_task = state == S_SCAN2 && last.valid;

  always_comb begin
    scan_head = '0;
    scan_head.valid = (state == S_SCAN1 || state == S_SCAN2) && (step == '0);
  end

  assign chain[0] = scan_head;

  always_comb begin
    ctrl = '0;
    ctrl.clear = accept && req.func == FUNC_CLEAR;
    ctrl.load = accept && req.func == FUNC_LOAD && server_count < CNT_W'(MAX_SERVERS);
    ctrl.weight = req.server_weight;
    ctrl.release_en = state == S_REL;
    ctrl.now = current_time;
    ctrl.assign_en = state == S_SCAN2 && last.valid;
    ctrl.fin = fin_sum[TIME_W] ? TIME_MAX : fin_sum[TIME_W-1:0];
  end

  for (genvar g = 0; g < MAX_SERVERS; g++) begin : g_cell
    cell_ctrl_t c;
    always_comb begin
      c = ctrl;
      c.load_sel = server_count[IDX_W-1:0] == IDX_W'(g);
      c.assign_sel = last.best_idx == IDX_W'(g);
    end
    wsts_cell u_cell (
      .clk(clk), .rst(rst), .idx(IDX_W'(g)), .ctrl(c),
      .scan_in(chain[g]), .scan_out(chain[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      server_count <= '0;
      current_time <= '0;
      task_counter <= '0;
      step <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (req.func)
              FUNC_CLEAR: begin
                server_count <= '0;
                current_time <= '0;
                task_counter <= '0;
              end
              FUNC_LOAD: begin
                if (ctrl.load) server_count <= server_count + 1'b1;
              end
              FUNC_TASK: begin
                arrival <= task_counter;
                dur <= req.task_duration;
                if (task_counter != TIME_MAX) task_counter <= task_counter + 1'b1;
                if (server_count != '0) begin
                  state <= S_SCAN1;
                  step <= '0;
                end
              end
              default: ;
            endcase
          end
        end
        S_SCAN1: begin
          step <= step + 1'b1;
          if (last.valid) begin
            state <= S_REL;
            if (last.idle_found) begin
              current_time <= current_time > arrival ? current_time : arrival;
            end else begin
              current_time <= last.earliest;
            end
          end
        end
        S_REL: begin
          state <= S_SCAN2;
          step <= '0;
        end
        S_SCAN2: begin
          step <= step + 1'b1;
          if (last.valid) state <= S_ASSIGN;
        end
        S_ASSIGN: begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
      res_pending <= 1'b0;
    end else if (res_set_empty || res_set_task) begin
      res.valid <= 1'b1;
      res_pending <= 1'b1;
      res.assigned_server <= res_set_task ? 4'(last.best_idx) : 4'd0;
      res.start_time <= res_set_task ? current_time : '0;
      res.no_server <= res_set_empty;
    end else if (res.valid && res.ready) begin
      res.valid <= 1'b0;
      res_pending <= 1'b0;
    end
  end
endmodule

FILE: hdl/wsts_checker.sv
// Checker: port-level properties of the scheduler, bound to the top level.
module wsts_checker (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input logic [1:0] req_func,
  input logic res_valid,
  input logic res_ready,
  input logic [47:0] res_start_time,
  input logic res_no_server
);
  import wsts_pkg::*;

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_start_time))
    else $error("result dropped while stalled");
  a_no_srv_time: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_no_server |-> res_start_time == 48'd0)
    else $error("no-server result carries time");
  a_task_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req_func == FUNC_TASK |=> !req_ready || res_valid)
    else $error("task finished with no result");
  a_reset: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result after reset");
endmodule

bind weighted_server_task_scheduler_core wsts_checker u_checker (
  .clk(clk), .rst(rst), .req_valid(req.valid), .req_ready(req.ready),
  .req_func(req.func), .res_valid(res.valid), .res_ready(res.ready),
  .res_start_time(res.start_time), .res_no_server(res.no_server)
);
